>>> src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGNL_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sgnl assertion failed");

// Next-cycle implication, disabled during reset
`define SGNL_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("sgnl assertion failed");

`endif

>>> src/sgnl_pkg.sv
package sgnl_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 32;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_LOAD_ACK    = 2'd0;
    localparam logic [1:0] KIND_HIT         = 2'd1;
    localparam logic [1:0] KIND_NONE        = 2'd2;
    localparam logic [1:0] KIND_DESTROY_ACK = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic load;
        logic q_none;
        logic rs_init;
        logic rs_step;
        logic rs_end;
        logic cs_init;
        logic cs_addr;
        logic cs_cmp;
        logic emit_r;
        logic emit_l;
        logic next_row;
        logic d_check;
        logic d_rd;
        logic d_wr;
        logic d_fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       table_empty;
        logic       srch_zero;
        logic       single_hit;
        logic       row_pending;
        logic       d_bad;
        logic       d_shift_done;
    } sts_t;

endpackage

>>> src/sgnl_ctrl.sv
module sgnl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sgnl_pkg::sts_t    sts,
    output sgnl_pkg::cmd_t    cmd,
    output logic              busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_RS_STEP  = 4'd2;
    localparam logic [3:0] S_RS_END   = 4'd3;
    localparam logic [3:0] S_CS_INIT  = 4'd4;
    localparam logic [3:0] S_CS_ADDR  = 4'd5;
    localparam logic [3:0] S_CS_CMP   = 4'd6;
    localparam logic [3:0] S_EMIT_R   = 4'd7;
    localparam logic [3:0] S_EMIT_L   = 4'd8;
    localparam logic [3:0] S_NEXT_ROW = 4'd9;
    localparam logic [3:0] S_D_CHECK  = 4'd10;
    localparam logic [3:0] S_D_LOOP   = 4'd11;
    localparam logic [3:0] S_D_WR     = 4'd12;
    localparam logic [3:0] S_D_FIN    = 4'd13;

    logic [3:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op)
                    sgnl_pkg::OP_LOAD:
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    sgnl_pkg::OP_QUERY:
                    begin
                        if (sts.table_empty)
                        begin
                            cmd.q_none = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rs_init = 1'b1;
                            state_next  = S_RS_STEP;
                        end
                    end
                    sgnl_pkg::OP_DESTROY:
                    begin
                        state_next = S_D_CHECK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RS_STEP:
            begin
                if (sts.srch_zero)
                begin
                    state_next = S_RS_END;
                end
                else
                begin
                    cmd.rs_step = 1'b1;
                end
            end
            S_RS_END:
            begin
                cmd.rs_end = 1'b1;
                state_next = S_CS_INIT;
            end
            S_CS_INIT:
            begin
                cmd.cs_init = 1'b1;
                state_next  = S_CS_ADDR;
            end
            S_CS_ADDR:
            begin
                if (sts.srch_zero)
                begin
                    state_next = S_EMIT_R;
                end
                else
                begin
                    cmd.cs_addr = 1'b1;
                    state_next  = S_CS_CMP;
                end
            end
            S_CS_CMP:
            begin
                cmd.cs_cmp = 1'b1;
                state_next = S_CS_ADDR;
            end
            S_EMIT_R:
            begin
                cmd.emit_r = 1'b1;
                if (!sts.single_hit)
                begin
                    state_next = S_EMIT_L;
                end
                else if (sts.row_pending)
                begin
                    state_next = S_NEXT_ROW;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_L:
            begin
                cmd.emit_l = 1'b1;
                state_next = sts.row_pending ? S_NEXT_ROW : S_IDLE;
            end
            S_NEXT_ROW:
            begin
                cmd.next_row = 1'b1;
                state_next   = S_CS_INIT;
            end
            S_D_CHECK:
            begin
                cmd.d_check = 1'b1;
                state_next  = sts.d_bad ? S_IDLE : S_D_LOOP;
            end
            S_D_LOOP:
            begin
                if (sts.d_shift_done)
                begin
                    state_next = S_D_FIN;
                end
                else
                begin
                    cmd.d_rd   = 1'b1;
                    state_next = S_D_WR;
                end
            end
            S_D_WR:
            begin
                cmd.d_wr   = 1'b1;
                state_next = S_D_LOOP;
            end
            S_D_FIN:
            begin
                cmd.d_fin  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/sgnl_dp.sv
module sgnl_dp #(
    parameter int MAX_ROWS = sgnl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = sgnl_pkg::MAX_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sgnl_pkg::cmd_t     cmd,
    output sgnl_pkg::sts_t     sts,
    input  logic [1:0]         operation,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic [3:0]         row_index,
    input  logic [4:0]         col_index,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [3:0]         hit_row,
    output logic [4:0]         hit_col,
    output logic               last
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int SW    = (RCW > ECW) ? RCW : ECW;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int IW    = (RCW > 4) ? RCW : 4;
    localparam int JW    = (ECW > 5) ? ECW : 5;

    // latched word
    logic [1:0]         op_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [3:0]         ri_reg;
    logic [4:0]         ci_reg;

    // table state
    logic [RCW-1:0]     row_count_reg;
    logic signed [15:0] row_y_reg [MAX_ROWS];
    logic [ECW-1:0]     cnt_reg [MAX_ROWS];
    logic [RW-1:0]      map_reg [MAX_ROWS];

    // search state
    logic [SW-1:0]      first_reg, count_reg;
    logic [RW-1:0]      row_a_reg, row_b_reg, cur_reg;
    logic               two_reg;
    logic [ECW-1:0]     idx_reg;

    // entry memory, one slot of MAX_COLS per physical row
    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_data_reg;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic signed [15:0] wr_data;

    // output word registers
    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         status_reg, status_next;
    logic [3:0]         hrow_reg, hrow_next;
    logic [4:0]         hcol_reg, hcol_next;
    logic               last_reg, last_next;

    // binary search step
    logic [SW-1:0]      step, probe;
    logic               row_go_right, col_go_right;

    // load decode
    logic [RCW-1:0]     rc_m1;
    logic [RW-1:0]      last_idx, rc_idx;
    logic               new_row, rows_full, row_full, load_ok;

    // emission
    logic [ECW-1:0]     row_m, c_e, right_col, left_col;
    logic               single;

    // destroy
    logic [RW-1:0]      ri_r;
    logic [ECW-1:0]     d_m;
    logic               d_bad;

    assign step         = count_reg >> 1;
    assign probe        = first_reg + step;
    assign row_go_right = row_y_reg[probe[RW-1:0]] > y_reg;
    assign col_go_right = rd_data_reg < x_reg;

    assign rc_m1     = row_count_reg - RCW'(1);
    assign last_idx  = rc_m1[RW-1:0];
    assign rc_idx    = RW'(row_count_reg);
    assign new_row   = (row_count_reg == '0) || (row_y_reg[last_idx] != y_reg);
    assign rows_full = row_count_reg >= RCW'(MAX_ROWS);
    assign row_full  = cnt_reg[last_idx] >= ECW'(MAX_COLS);
    assign load_ok   = new_row ? !rows_full : !row_full;

    // hit columns around the lower bound
    assign row_m = cnt_reg[cur_reg];
    assign c_e   = ECW'(first_reg);
    always_comb
    begin
        if (c_e == '0)
        begin
            right_col = '0;
            left_col  = '0;
        end
        else if (c_e >= row_m)
        begin
            right_col = row_m - ECW'(1);
            left_col  = row_m - ECW'(1);
        end
        else
        begin
            right_col = c_e;
            left_col  = c_e - ECW'(1);
        end
    end
    assign single = (right_col == left_col);

    assign ri_r  = RW'(ri_reg);
    assign d_m   = cnt_reg[ri_r];
    assign d_bad = (IW'(ri_reg) >= IW'(row_count_reg)) || (JW'(ci_reg) >= JW'(d_m));

    // status to controller
    assign sts.op           = op_reg;
    assign sts.table_empty  = (row_count_reg == '0);
    assign sts.srch_zero    = (count_reg == '0);
    assign sts.single_hit   = single;
    assign sts.row_pending  = two_reg && (cur_reg == row_a_reg);
    assign sts.d_bad        = d_bad;
    assign sts.d_shift_done = (idx_reg + ECW'(1)) >= d_m;

    // memory port addressing
    always_comb
    begin
        if (cmd.d_rd)
        begin
            rd_addr = {map_reg[ri_r], CW'(idx_reg + ECW'(1))};
        end
        else
        begin
            rd_addr = {map_reg[cur_reg], probe[CW-1:0]};
        end
        wr_en   = 1'b0;
        wr_addr = {map_reg[ri_r], CW'(idx_reg)};
        wr_data = rd_data_reg;
        if (cmd.load && load_ok)
        begin
            wr_en   = 1'b1;
            wr_data = x_reg;
            if (new_row)
            begin
                wr_addr = {map_reg[rc_idx], CW'(0)};
            end
            else
            begin
                wr_addr = {map_reg[last_idx], cnt_reg[last_idx][CW-1:0]};
            end
        end
        else if (cmd.d_wr)
        begin
            wr_en = 1'b1;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // latched word and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= operation;
            x_reg  <= x_pos;
            y_reg  <= y_pos;
            ri_reg <= row_index;
            ci_reg <= col_index;
        end
        if (cmd.rs_init)
        begin
            first_reg <= '0;
            count_reg <= SW'(row_count_reg);
        end
        if (cmd.rs_step)
        begin
            if (row_go_right)
            begin
                first_reg <= probe + SW'(1);
                count_reg <= count_reg - step - SW'(1);
            end
            else
            begin
                count_reg <= step;
            end
        end
        if (cmd.rs_end)
        begin
            if (first_reg == '0)
            begin
                row_a_reg <= '0;
                row_b_reg <= '0;
                cur_reg   <= '0;
                two_reg   <= 1'b0;
            end
            else if (first_reg >= SW'(row_count_reg))
            begin
                row_a_reg <= last_idx;
                row_b_reg <= last_idx;
                cur_reg   <= last_idx;
                two_reg   <= 1'b0;
            end
            else
            begin
                row_a_reg <= RW'(first_reg - SW'(1));
                row_b_reg <= RW'(first_reg);
                cur_reg   <= RW'(first_reg - SW'(1));
                two_reg   <= 1'b1;
            end
        end
        if (cmd.next_row)
        begin
            cur_reg <= row_b_reg;
        end
        if (cmd.cs_init)
        begin
            first_reg <= '0;
            count_reg <= SW'(cnt_reg[cur_reg]);
        end
        if (cmd.cs_cmp)
        begin
            if (col_go_right)
            begin
                first_reg <= probe + SW'(1);
                count_reg <= count_reg - step - SW'(1);
            end
            else
            begin
                count_reg <= step;
            end
        end
        if (cmd.d_check)
        begin
            idx_reg <= ECW'(ci_reg);
        end
        if (cmd.d_wr)
        begin
            idx_reg <= idx_reg + ECW'(1);
        end
    end

    // row Y values, shifted down when a row is removed
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok && new_row)
        begin
            row_y_reg[rc_idx] <= y_reg;
        end
        if (cmd.d_fin && (d_m == ECW'(1)))
        begin
            for (int i = 0; i < MAX_ROWS - 1; i++)
            begin
                if (RW'(i) >= ri_r)
                begin
                    row_y_reg[i] <= row_y_reg[i + 1];
                end
            end
        end
    end

    // row count, entry counts and physical slot map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                cnt_reg[i] <= '0;
                map_reg[i] <= RW'(i);
            end
        end
        else if (cmd.load && load_ok)
        begin
            if (new_row)
            begin
                cnt_reg[rc_idx] <= ECW'(1);
                row_count_reg   <= row_count_reg + RCW'(1);
            end
            else
            begin
                cnt_reg[last_idx] <= cnt_reg[last_idx] + ECW'(1);
            end
        end
        else if (cmd.d_fin)
        begin
            if (d_m == ECW'(1))
            begin
                // drop the row, its slot moves to the last used position
                for (int i = 0; i < MAX_ROWS - 1; i++)
                begin
                    if ((RW'(i) >= ri_r) && (RW'(i) < last_idx))
                    begin
                        cnt_reg[i] <= cnt_reg[i + 1];
                        map_reg[i] <= map_reg[i + 1];
                    end
                end
                map_reg[last_idx] <= map_reg[ri_r];
                row_count_reg     <= rc_m1;
            end
            else
            begin
                cnt_reg[ri_r] <= d_m - ECW'(1);
            end
        end
    end

    // result word
    always_comb
    begin
        valid_next  = 1'b0;
        kind_next   = sgnl_pkg::KIND_LOAD_ACK;
        status_next = sgnl_pkg::ST_OK;
        hrow_next   = '0;
        hcol_next   = '0;
        last_next   = 1'b1;
        if (cmd.load)
        begin
            valid_next  = 1'b1;
            status_next = load_ok ? sgnl_pkg::ST_OK : sgnl_pkg::ST_FULL;
        end
        else if (cmd.q_none)
        begin
            valid_next = 1'b1;
            kind_next  = sgnl_pkg::KIND_NONE;
        end
        else if (cmd.emit_r || cmd.emit_l)
        begin
            valid_next = 1'b1;
            kind_next  = sgnl_pkg::KIND_HIT;
            hrow_next  = 4'(cur_reg);
            hcol_next  = cmd.emit_r ? 5'(right_col) : 5'(left_col);
            last_next  = !(two_reg && (cur_reg == row_a_reg)) && (cmd.emit_l || single);
        end
        else if (cmd.d_check && d_bad)
        begin
            valid_next  = 1'b1;
            kind_next   = sgnl_pkg::KIND_DESTROY_ACK;
            status_next = sgnl_pkg::ST_RANGE;
        end
        else if (cmd.d_fin)
        begin
            valid_next = 1'b1;
            kind_next  = sgnl_pkg::KIND_DESTROY_ACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        hrow_reg   <= hrow_next;
        hcol_reg   <= hcol_next;
        last_reg   <= last_next;
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign hit_row      = hrow_reg;
    assign hit_col      = hcol_reg;
    assign last         = last_reg;

endmodule

>>> src/sorted_grid_neighbor_lookup.sv
// Order of work: a load answers from dispatch; a destroy checks its indices, shifts each
// entry behind the removed one (read, then write) and finishes, dropping an emptied row
// there; a query runs a row search, then a column search (address, compare) in each hit
// row, emitting its hits. One word at a time: busy falls as the last result word comes
// out, so the next word can be accepted in that cycle. Results are single-cycle strobes;
// the receiver cannot stall. Reset (rst_n low, async) empties the table.
`include "assert_macros.svh"

module sorted_grid_neighbor_lookup #(
    parameter int MAX_ROWS = sgnl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = sgnl_pkg::MAX_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic [3:0]         row_index,
    input  logic [4:0]         col_index,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic [1:0]         status,
    output logic [3:0]         hit_row,
    output logic [4:0]         hit_col,
    output logic               last
);

    sgnl_pkg::cmd_t cmd;
    sgnl_pkg::sts_t sts;
    logic           ack_word;
    logic           query_word;

    sgnl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    sgnl_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .row_index    (row_index),
        .col_index    (col_index),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .hit_row      (hit_row),
        .hit_col      (hit_col),
        .last         (last)
    );

    // word classes for the checks below
    assign ack_word   = result_valid && (kind != sgnl_pkg::KIND_HIT);
    assign query_word = result_valid &&
                        ((kind == sgnl_pkg::KIND_NONE) || (kind == sgnl_pkg::KIND_HIT));

    // a result word only follows a busy cycle
    `SGNL_ASSERT_IMP(a_result_after_busy, clk, rst_n, result_valid, $past(busy))
    // an accepted word makes the block busy
    `SGNL_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // acks and none results are single words
    `SGNL_ASSERT_IMP(a_single_last, clk, rst_n, ack_word, last)
    // none results and hits carry ok status
    `SGNL_ASSERT_IMP(a_query_ok, clk, rst_n, query_word, status == sgnl_pkg::ST_OK)

endmodule

>>> verif/sorted_grid_neighbor_lookup_tb.sv
module sorted_grid_neighbor_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = 16;
    localparam int NCOLS = 32;

    // operation code with no function
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         operation;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [3:0]         row_index;
    logic [4:0]         col_index;
    logic               result_valid;
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [3:0]         hit_row;
    logic [4:0]         hit_col;
    logic               last;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [3:0] hit_row;
        logic [4:0] hit_col;
        logic       last;
    } result_word_t;

    result_word_t expected_words[$];
    int fail_count;

    // shadow copy of the grid table
    int                 grid_rows;
    logic signed [15:0] grid_y [NROWS];
    int                 grid_len [NROWS];
    logic signed [15:0] grid_x [NROWS][NCOLS];

    sorted_grid_neighbor_lookup dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("sorted_grid_neighbor_lookup_tb failed");
        $finish;
    end

    function automatic void push_word(logic [1:0] k, logic [1:0] st, int r, int c, bit l);
        result_word_t w;
        w.kind = k;
        w.status = st;
        w.hit_row = r[3:0];
        w.hit_col = c[4:0];
        w.last = l;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // first row whose Y is at most y
    function automatic int first_row_at_or_below(logic signed [15:0] y);
        int lo, cnt, half;
        lo = 0;
        cnt = grid_rows;
        while (cnt > 0)
        begin
            half = cnt / 2;
            if (grid_y[lo + half] > y)
            begin
                lo = lo + half + 1;
                cnt = cnt - half - 1;
            end
            else
                cnt = half;
        end
        return lo;
    endfunction

    // hits within one row: right neighbor first, then left
    function automatic void predict_row_hits(int r, logic signed [15:0] x);
        int lo, cnt, half, n, lft, rgt;
        lo = 0;
        n = grid_len[r];
        cnt = n;
        while (cnt > 0)
        begin
            half = cnt / 2;
            if (grid_x[r][lo + half] < x)
            begin
                lo = lo + half + 1;
                cnt = cnt - half - 1;
            end
            else
                cnt = half;
        end
        if (lo == 0)
        begin
            lft = 0;
            rgt = 0;
        end
        else if (lo >= n)
        begin
            lft = n - 1;
            rgt = n - 1;
        end
        else
        begin
            lft = lo - 1;
            rgt = lo;
        end
        push_word(sgnl_pkg::KIND_HIT, sgnl_pkg::ST_OK, r, rgt, 1'b0);
        if (lft != rgt)
            push_word(sgnl_pkg::KIND_HIT, sgnl_pkg::ST_OK, r, lft, 1'b0);
    endfunction

    function automatic void predict_word(logic [1:0] op, logic signed [15:0] x,
                                         logic signed [15:0] y, int ri, int ci);
        int r, a, b;
        logic [1:0] st;
        if (op == sgnl_pkg::OP_LOAD)
        begin
            st = sgnl_pkg::ST_OK;
            if (grid_rows == 0 || grid_y[grid_rows - 1] != y)
            begin
                if (grid_rows >= NROWS)
                    st = sgnl_pkg::ST_FULL;
                else
                begin
                    grid_y[grid_rows] = y;
                    grid_len[grid_rows] = 0;
                    grid_rows++;
                end
            end
            else if (grid_len[grid_rows - 1] >= NCOLS)
                st = sgnl_pkg::ST_FULL;
            if (st == sgnl_pkg::ST_OK)
            begin
                r = grid_rows - 1;
                grid_x[r][grid_len[r]] = x;
                grid_len[r]++;
            end
            push_word(sgnl_pkg::KIND_LOAD_ACK, st, 0, 0, 1'b1);
        end
        else if (op == sgnl_pkg::OP_DESTROY)
        begin
            if (ri >= grid_rows || ci >= grid_len[ri])
                push_word(sgnl_pkg::KIND_DESTROY_ACK, sgnl_pkg::ST_RANGE, 0, 0, 1'b1);
            else
            begin
                for (int i = ci; i + 1 < grid_len[ri]; i++)
                    grid_x[ri][i] = grid_x[ri][i + 1];
                grid_len[ri]--;
                if (grid_len[ri] == 0)
                begin
                    for (int i = ri; i + 1 < grid_rows; i++)
                    begin
                        grid_y[i] = grid_y[i + 1];
                        grid_len[i] = grid_len[i + 1];
                        grid_x[i] = grid_x[i + 1];
                    end
                    grid_rows--;
                end
                push_word(sgnl_pkg::KIND_DESTROY_ACK, sgnl_pkg::ST_OK, 0, 0, 1'b1);
            end
        end
        else if (op == sgnl_pkg::OP_QUERY)
        begin
            if (grid_rows == 0)
                push_word(sgnl_pkg::KIND_NONE, sgnl_pkg::ST_OK, 0, 0, 1'b1);
            else
            begin
                r = first_row_at_or_below(y);
                if (r == 0)
                begin
                    a = 0;
                    b = 0;
                end
                else if (r >= grid_rows)
                begin
                    a = grid_rows - 1;
                    b = a;
                end
                else
                begin
                    a = r - 1;
                    b = r;
                end
                predict_row_hits(a, x);
                if (a != b)
                    predict_row_hits(b, x);
                expected_words[$].last = 1'b1;
            end
        end
    endfunction

    // send one word after a random gap; start stays high when the next word follows at once
    task automatic send_word(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                             int ri = 0, int ci = 0, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        x_pos <= x;
        y_pos <= y;
        row_index <= ri[3:0];
        col_index <= ci[4:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(op, x, y, ri, ci);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word kind=%0d", kind);
                fail_count++;
            end
            else
            begin
                result_word_t w;
                w = expected_words.pop_front();
                if (kind !== w.kind)
                begin
                    $error("kind: expected %0d, got %0d", w.kind, kind);
                    fail_count++;
                end
                if (status !== w.status)
                begin
                    $error("status: expected %0d, got %0d", w.status, status);
                    fail_count++;
                end
                if (hit_row !== w.hit_row)
                begin
                    $error("hit_row: expected %0d, got %0d", w.hit_row, hit_row);
                    fail_count++;
                end
                if (hit_col !== w.hit_col)
                begin
                    $error("hit_col: expected %0d, got %0d", w.hit_col, hit_col);
                    fail_count++;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, last);
                    fail_count++;
                end
            end
        end
    end

    // empty table, field extremes, full row and full table, bad destroys
    task automatic test_directed();
        send_word(sgnl_pkg::OP_QUERY, 16'sh7fff, 16'sh8000);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 0, 0);
        send_word(OP_SPARE, 16'sh7fff, 16'sh7fff, 15, 31);
        send_word(sgnl_pkg::OP_LOAD, 16'sh8000, 16'sh7fff);
        send_word(sgnl_pkg::OP_LOAD, 16'sh0000, 16'sh7fff);
        send_word(sgnl_pkg::OP_LOAD, 16'sh7fff, 16'sh7fff);
        send_word(sgnl_pkg::OP_QUERY, 16'sh8000, 16'sh7fff);
        send_word(sgnl_pkg::OP_QUERY, 16'sh0001, 16'sh8000);
        send_word(sgnl_pkg::OP_QUERY, 16'sh7fff, 16'sh7fff, 0, 0, 1);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 15, 0);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 0, 31);
        // fill row 0 to its limit, then one more
        for (int i = 3; i < NCOLS + 1; i++)
            send_word(sgnl_pkg::OP_LOAD, 16'(i * 64), 16'sh7fff, 0, 0, 1);
        // fill the table with rows, then one more
        for (int r = 1; r < NROWS + 1; r++)
            send_word(sgnl_pkg::OP_LOAD, 16'(r * 100), 16'(32000 - r * 4000), 0, 0, 1);
        send_word(sgnl_pkg::OP_QUERY, 16'sh0100, 16'sh1000);
        send_word(sgnl_pkg::OP_QUERY, 16'sh0100, 16'sh8000);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 0, 0);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 15, 0);
        send_word(sgnl_pkg::OP_DESTROY, 0, 0, 1, 0);
        drain();
    endtask

    // destroy everything left, random order
    task automatic test_clear_table();
        while (grid_rows > 0)
            send_word(sgnl_pkg::OP_DESTROY, 0, 0, $urandom_range(0, grid_rows - 1), 0);
        send_word(sgnl_pkg::OP_QUERY, 16'($urandom), 16'($urandom));
        drain();
    endtask

    // sorted tables with random content, mixed with queries, destroys and noise
    task automatic test_random();
        int nrows, ncols, ybase, xbase, sent, ri;
        sent = 0;
        while (sent < 20)
        begin
            nrows = $urandom_range(1, 5);
            ybase = $urandom_range(20000, 32767);
            for (int r = 0; r < nrows; r++)
            begin
                ncols = $urandom_range(1, 6);
                xbase = -$urandom_range(0, 32768);
                ybase = ybase - $urandom_range(1, 10000);
                for (int c = 0; c < ncols; c++)
                begin
                    xbase = xbase + $urandom_range(1, 9000);
                    if (xbase > 32767)
                        xbase = 32767;
                    send_word(sgnl_pkg::OP_LOAD, 16'(xbase), 16'(ybase));
                    sent++;
                end
            end
            for (int q = 0; q < 8; q++)
            begin
                case ($urandom_range(0, 9))
                    0: send_word(sgnl_pkg::OP_LOAD, 16'($urandom), 16'($urandom));
                    1, 2:
                    begin
                        ri = grid_rows > 0 ? $urandom_range(0, grid_rows - 1) : 0;
                        send_word(sgnl_pkg::OP_DESTROY, 0, 0, ri, $urandom_range(0, 5));
                    end
                    3: send_word(sgnl_pkg::OP_DESTROY, 16'($urandom), 16'($urandom),
                                 $urandom_range(0, 15), $urandom_range(0, 31));
                    4: send_word(OP_SPARE, 16'($urandom), 16'($urandom));
                    default: send_word(sgnl_pkg::OP_QUERY, 16'($urandom), 16'($urandom));
                endcase
                sent++;
            end
            // hold off until every result is in
            if ($urandom_range(0, 3) == 0)
                drain();
            if (grid_rows > 10)
                test_clear_table();
        end
        drain();
    endtask

    initial
    begin
        fail_count = 0;
        grid_rows = 0;
        foreach (grid_len[i])
            grid_len[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = sgnl_pkg::OP_LOAD;
        x_pos = '0;
        y_pos = '0;
        row_index = '0;
        col_index = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_clear_table();
        test_random();
        test_clear_table();
        if (fail_count == 0)
            $display("sorted_grid_neighbor_lookup_tb passed");
        else
            $display("sorted_grid_neighbor_lookup_tb failed");
        $finish;
    end
endmodule
